// ===== design/distributed_flow_shop_makespan_assert.svh =====
// assertion macros used by the flow shop makespan rtl
`ifndef DISTRIBUTED_FLOW_SHOP_MAKESPAN_ASSERT_SVH
`define DISTRIBUTED_FLOW_SHOP_MAKESPAN_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DFSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DFSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dfsm_pkg.sv =====
// shared types and constants of the flow shop makespan block
`default_nettype none

package dfsm_pkg;

    localparam int ROW_W  = 32;
    localparam int PROC_W = 16;
    localparam int CFG_W  = 6;

    localparam logic KIND_TIME = 1'b0;
    localparam logic KIND_SEP  = 1'b1;

    typedef struct packed {
        logic wr;
        logic first;
        logic fwd;
        logic no_left;
    } t_row_ctl;

endpackage

`default_nettype wire

// ===== design/dfsm_row_unit.sv =====
// completion row memory with forwarding and the saturating add-max
`default_nettype none

module dfsm_row_unit #(
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rd_en,
    input  wire logic [ADDR_W-1:0]            i_rd_addr,
    input  wire logic [ADDR_W-1:0]            i_wr_addr,
    input  wire dfsm_pkg::t_row_ctl           i_ctl,
    input  wire logic [dfsm_pkg::PROC_W-1:0]  i_time,
    input  wire logic [dfsm_pkg::ROW_W-1:0]   i_left,
    output logic      [dfsm_pkg::ROW_W-1:0]   o_val,
    output logic                              o_sat
);

    logic [dfsm_pkg::ROW_W-1:0] r_mem [DEPTH];
    logic [dfsm_pkg::ROW_W-1:0] r_rd_q;
    logic [dfsm_pkg::ROW_W-1:0] r_fwd_val;

    logic [dfsm_pkg::ROW_W-1:0] up;
    logic [dfsm_pkg::ROW_W-1:0] left;
    logic [dfsm_pkg::ROW_W-1:0] base;
    logic [dfsm_pkg::ROW_W:0]   sum;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= o_val;
            r_fwd_val        <= o_val;
        end
    end

    always_comb begin
        up    = i_ctl.first ? '0 : (i_ctl.fwd ? r_fwd_val : r_rd_q);
        left  = i_ctl.no_left ? '0 : i_left;
        base  = (left > up) ? left : up;
        sum   = {1'b0, base} + {{(dfsm_pkg::ROW_W + 1 - dfsm_pkg::PROC_W){1'b0}}, i_time};
        o_sat = sum[dfsm_pkg::ROW_W];
        o_val = o_sat ? '1 : sum[dfsm_pkg::ROW_W-1:0];
    end

endmodule

`default_nettype wire

// ===== design/distributed_flow_shop_makespan.sv =====
// Distributed permutation flow shop makespan engine. Items stream in one per clock
// cycle, sustained, with no bubbles between jobs, machines or factories. Each item is
// accepted into a decode stage that picks the machine slot and issues a read of the
// completion row memory; the evaluate stage then applies time + max(left, up) with
// saturation and writes the row entry back, so the registered row memory read and the
// single add-max stage set the rate. When the same row entry is read and written in
// consecutive cycles (a single-machine shop) the fresh value is forwarded. The result
// for an end-of-sequence item is captured when that item leaves the evaluate stage and
// is held in an output register, so input keeps flowing while it waits; only a
// further end-of-sequence item stalls behind an untaken result. The row memory needs
// no clearing after reset. Write num_machines only while the block is idle.
`default_nettype none
`include "distributed_flow_shop_makespan_assert.svh"

module distributed_flow_shop_makespan #(
    parameter int MAX_MACHINES = 32,
    parameter int TIME_BITS    = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [dfsm_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_kind,
    input  wire logic [dfsm_pkg::PROC_W-1:0]  i_proc_time,
    input  wire logic                         i_end_of_sequence,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [dfsm_pkg::ROW_W-1:0]   o_makespan,
    output logic                              o_overflow
);

    localparam int IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CNT_B = $clog2(MAX_MACHINES + 1);
    localparam int CW    = (CNT_B > dfsm_pkg::CFG_W) ? CNT_B : dfsm_pkg::CFG_W;
    localparam logic [CW-1:0] MAX_M = CW'(MAX_MACHINES);
    localparam logic [dfsm_pkg::PROC_W-1:0] TIME_MASK =
        (TIME_BITS >= dfsm_pkg::PROC_W) ? '1 : dfsm_pkg::PROC_W'((1 << TIME_BITS) - 1);

    // configuration and decode state
    logic [dfsm_pkg::CFG_W-1:0] r_num_machines;
    logic [IDX_W-1:0]           r_machine_index;
    logic                       r_first_job;

    // evaluate stage
    logic                        r_s1_valid;
    logic                        r_s1_kind;
    logic                        r_s1_eos;
    logic [dfsm_pkg::PROC_W-1:0] r_s1_time;
    logic [IDX_W-1:0]            r_s1_j;
    logic                        r_s1_first;
    logic                        r_s1_last;
    logic                        r_s1_fwd;

    // value state
    logic [dfsm_pkg::ROW_W-1:0] r_left;
    logic [dfsm_pkg::ROW_W-1:0] r_last_fin;
    logic [dfsm_pkg::ROW_W-1:0] r_best;
    logic                       r_ovf;
    logic [dfsm_pkg::ROW_W-1:0] n_left;
    logic [dfsm_pkg::ROW_W-1:0] n_last_fin;
    logic [dfsm_pkg::ROW_W-1:0] n_best;
    logic                       n_ovf;
    logic [dfsm_pkg::ROW_W-1:0] n_result;

    // result register
    logic                       r_out_valid;
    logic [dfsm_pkg::ROW_W-1:0] r_makespan;
    logic                       r_overflow;

    logic [CW-1:0]      used_m;
    logic [CW-1:0]      last_m;
    logic               at_last;
    logic [IDX_W-1:0]   cur_j;
    logic               in_acc;
    logic               s1_fire;
    logic               s1_wr;
    dfsm_pkg::t_row_ctl row_ctl;
    logic [dfsm_pkg::ROW_W-1:0] row_val;
    logic                       row_sat;

    always_comb begin
        priority if (r_num_machines == '0) begin
            used_m = CW'(1);
        end else if (CW'(r_num_machines) > MAX_M) begin
            used_m = MAX_M;
        end else begin
            used_m = CW'(r_num_machines);
        end
        last_m  = used_m - CW'(1);
        at_last = CW'(r_machine_index) >= last_m;
        cur_j   = at_last ? last_m[IDX_W-1:0] : r_machine_index;
    end

    assign s1_fire     = r_s1_valid && (!r_s1_eos || !r_out_valid || i_out_ready);
    assign s1_wr       = s1_fire && (r_s1_kind == dfsm_pkg::KIND_TIME);
    assign o_in_ready  = !r_s1_valid || s1_fire;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_machines <= dfsm_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_num_machines <= i_cfg_data;
        end
    end

    // decode stage: machine slot and row read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine_index <= '0;
            r_first_job     <= 1'b1;
            r_s1_valid      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                if (i_end_of_sequence || i_kind == dfsm_pkg::KIND_SEP) begin
                    r_machine_index <= '0;
                    r_first_job     <= 1'b1;
                end else if (at_last) begin
                    r_machine_index <= '0;
                    r_first_job     <= 1'b0;
                end else begin
                    r_machine_index <= r_machine_index + IDX_W'(1);
                end
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind  <= i_kind;
            r_s1_eos   <= i_end_of_sequence;
            r_s1_time  <= i_proc_time & TIME_MASK;
            r_s1_j     <= cur_j;
            r_s1_first <= r_first_job;
            r_s1_last  <= at_last;
            r_s1_fwd   <= s1_wr && (r_s1_j == cur_j);
        end
    end

    assign row_ctl.wr      = s1_wr;
    assign row_ctl.first   = r_s1_first;
    assign row_ctl.fwd     = r_s1_fwd;
    assign row_ctl.no_left = (r_s1_j == '0);

    dfsm_row_unit #(
        .DEPTH (MAX_MACHINES)
    ) u_row (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_j),
        .i_wr_addr (r_s1_j),
        .i_ctl     (row_ctl),
        .i_time    (r_s1_time),
        .i_left    (r_left),
        .o_val     (row_val),
        .o_sat     (row_sat)
    );

    // evaluate stage: fold finishes
    always_comb begin
        n_left     = r_left;
        n_last_fin = r_last_fin;
        n_best     = r_best;
        n_ovf      = r_ovf;
        if (r_s1_kind == dfsm_pkg::KIND_TIME) begin
            n_ovf  = r_ovf | row_sat;
            n_left = r_s1_last ? '0 : row_val;
            if (r_s1_last) begin
                n_last_fin = row_val;
            end
        end else begin
            n_best     = (r_last_fin > r_best) ? r_last_fin : r_best;
            n_last_fin = '0;
            n_left     = '0;
        end
        n_result = (n_last_fin > n_best) ? n_last_fin : n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_last_fin  <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire && r_s1_eos) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                if (r_s1_eos) begin
                    r_left     <= '0;
                    r_last_fin <= '0;
                    r_best     <= '0;
                    r_ovf      <= 1'b0;
                end else begin
                    r_left     <= n_left;
                    r_last_fin <= n_last_fin;
                    r_best     <= n_best;
                    r_ovf      <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_eos) begin
            r_makespan <= n_result;
            r_overflow <= n_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_makespan  = r_makespan;
    assign o_overflow  = r_overflow;

    `DFSM_ASSERT_NOW(a_ready_when_empty, !r_s1_valid, o_in_ready, "input stalled with empty stage")
    `DFSM_ASSERT_NOW(a_result_from_eos, $rose(r_out_valid), $past(s1_fire && r_s1_eos),
        "result without end of sequence")
    `DFSM_ASSERT_NEXT(a_clear_after_eos, s1_fire && r_s1_eos,
        r_best == '0 && r_last_fin == '0 && !r_ovf, "sequence state not cleared")

endmodule

`default_nettype wire
